// File: rtl/hrbp_pkg.sv
`timescale 1ns / 1ps
package hrbp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_request;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  byte_class;
    logic [7:0]  out_byte;
    logic        header_line_end;
    logic [3:0]  method_code;
    logic        version_major;
    logic [13:0] version_minor;
    logic [22:0] body_length;
  } out_word_t;

  localparam logic [3:0] ST_PROGRESS = 4'd0;
  localparam logic [3:0] ST_OK       = 4'd1;
  localparam logic [3:0] ST_BAD_METH = 4'd2;
  localparam logic [3:0] ST_BAD_URI  = 4'd3;
  localparam logic [3:0] ST_URI_LONG = 4'd4;
  localparam logic [3:0] ST_BAD_VER  = 4'd5;
  localparam logic [3:0] ST_NL1_ERR  = 4'd6;
  localparam logic [3:0] ST_DONE     = 4'd7;
  localparam logic [3:0] ST_KEY_ERR  = 4'd8;
  localparam logic [3:0] ST_VAL_ERR  = 4'd9;
  localparam logic [3:0] ST_NL2_ERR  = 4'd10;
  localparam logic [3:0] ST_HDR_BIG  = 4'd11;

  localparam logic [2:0] CL_NONE  = 3'd0;
  localparam logic [2:0] CL_METH  = 3'd1;
  localparam logic [2:0] CL_URI   = 3'd2;
  localparam logic [2:0] CL_NAME  = 3'd3;
  localparam logic [2:0] CL_VALUE = 3'd4;
  localparam logic [2:0] CL_BODY  = 3'd5;

  localparam logic [0:0] REG_HDR_LIMIT = 1'd0;
  localparam logic [0:0] REG_URI_LIMIT = 1'd1;

  // byte class flags computed by the front end
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] lo;
    logic       clr;
    logic       alpha;
    logic       digit;
    logic       ctl;
    logic       token;
    logic       sp;
    logic       tab;
    logic       cr;
    logic       lf;
  } cls_word_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "c";
      4'd1: r = "o";
      4'd2: r = "n";
      4'd3: r = "t";
      4'd4: r = "e";
      4'd5: r = "n";
      4'd6: r = "t";
      4'd7: r = "-";
      4'd8: r = "l";
      4'd9: r = "e";
      4'd10: r = "n";
      4'd11: r = "g";
      4'd12: r = "t";
      4'd13: r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/hrbp_front.sv
`timescale 1ns / 1ps
module hrbp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  hrbp_pkg::in_word_t  data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output hrbp_pkg::cls_word_t data_o
);
  logic                valid_q;
  hrbp_pkg::cls_word_t data_q, cls_d;
  logic [7:0]          c;
  logic                special;

  always_comb begin
    c = data_i.in_byte;
    special = c inside {8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c,
                        8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20,
                        8'h09};
    cls_d.b     = c;
    cls_d.lo    = hrbp_pkg::to_lower(c);
    cls_d.clr   = data_i.new_request;
    cls_d.alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    cls_d.digit = c >= 8'h30 && c <= 8'h39;
    cls_d.ctl   = c <= 8'd31 || c == 8'd127;
    cls_d.token = c <= 8'd127 && !cls_d.ctl && !special;
    cls_d.sp    = c == 8'h20;
    cls_d.tab   = c == 8'h09;
    cls_d.cr    = c == 8'h0d;
    cls_d.lf    = c == 8'h0a;
  end

  assign stall_o = valid_q && stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) data_q <= cls_d;
  end
endmodule

// File: rtl/hrbp_queue.sv
`timescale 1ns / 1ps
module hrbp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  hrbp_pkg::cls_word_t data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output hrbp_pkg::cls_word_t data_o
);
  hrbp_pkg::cls_word_t mem_q [2];
  logic                wp_q, rp_q;
  logic [1:0]          cnt_q;
  logic                push, pop;

  assign valid_o = cnt_q != 2'd0;
  assign stall_o = cnt_q == 2'd2;
  assign data_o  = mem_q[rp_q];
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule

// File: rtl/hrbp_back.sv
`timescale 1ns / 1ps
module hrbp_back #(
  parameter int METHOD_MAX_LEN   = 8,
  parameter int BODY_MAX         = 4194304,
  parameter int MINOR_MAX_DIGITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          hdr_limit_i,
  input  logic [15:0]          uri_limit_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  hrbp_pkg::cls_word_t  data_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output hrbp_pkg::out_word_t  data_o
);
  localparam int ML = $clog2(METHOD_MAX_LEN + 1);
  localparam int MI = $clog2(METHOD_MAX_LEN);
  localparam logic [24:0] BMAX   = 25'(BODY_MAX);
  localparam logic [24:0] BMAX10 = 25'(BODY_MAX / 10);

  typedef enum logic [1:0] {PH_LINE, PH_HEAD, PH_BODY, PH_DONE} phase_e;
  typedef enum logic [3:0] {L_MSTART, L_METHOD, L_URI, L_H, L_T1, L_T2, L_P, L_SLASH,
                            L_MAJ, L_DOT, L_MINSTART, L_MINOR, L_NL1} line_e;
  typedef enum logic [2:0] {H_START, H_LWS, H_NAME, H_VALUE, H_NL2, H_NL3} head_e;

  phase_e      ph_q, ph_d, ph_c;
  line_e       ls_q, ls_d, ls_c;
  head_e       hs_q, hs_d, hs_c;
  logic [7:0]  mch_q [METHOD_MAX_LEN];
  logic [7:0]  mch_d [METHOD_MAX_LEN];
  logic [7:0]  mch_c [METHOD_MAX_LEN];
  logic [ML-1:0] mlen_q, mlen_d, mlen_c;
  logic [3:0]  mval_q, mval_d, mval_c;
  logic [15:0] ulen_q, ulen_d, ulen_c;
  logic        maj_q, maj_d, maj_c;
  logic [13:0] min_q, min_d, min_c;
  logic [2:0]  mdig_q, mdig_d, mdig_c;
  logic [16:0] hb_q, hb_d, hb_c;
  logic        nne_q, nne_d, nne_c;
  logic [4:0]  mpos_q, mpos_d, mpos_c;
  logic        mok_q, mok_d, mok_c;
  logic        lseen_q, lseen_d, lseen_c;
  logic [24:0] lval_q, lval_d, lval_c;
  logic        lvld_q, lvld_d, lvld_c;
  logic [24:0] bcnt_q, bcnt_d, bcnt_c;

  logic        out_v_q;
  hrbp_pkg::out_word_t out_q, out_d;
  logic        take;
  logic [3:0]  st, mcode;
  logic [2:0]  cls;
  logic [7:0]  ob;
  logic        hle, is_cl;
  logic [24:0] bsize, blen;
  logic [28:0] lv10;
  logic [24:0] nv;

  function automatic logic [3:0] lookup(input logic [7:0] ch [METHOD_MAX_LEN],
                                        input logic [ML-1:0] n);
    logic [63:0] w;
    logic [3:0]  r;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < METHOD_MAX_LEN && i < int'(n)) w[63-8*i -: 8] = ch[i];
    end
    r = 4'd0;
    if (n == ML'(3) && w[63:40] == "GET") r = 4'd1;
    if (n == ML'(4) && w[63:32] == "HEAD") r = 4'd2;
    if (n == ML'(4) && w[63:32] == "POST") r = 4'd3;
    if (n == ML'(3) && w[63:40] == "PUT") r = 4'd4;
    if (n == ML'(6) && w[63:16] == "DELETE") r = 4'd5;
    if (n == ML'(7) && w[63:8] == "CONNECT") r = 4'd6;
    if (n == ML'(7) && w[63:8] == "OPTIONS") r = 4'd7;
    if (n == ML'(5) && w[63:24] == "TRACE") r = 4'd8;
    if (n == ML'(5) && w[63:24] == "PATCH") r = 4'd9;
    return r;
  endfunction

  assign stall_o = out_v_q && stall_i;
  assign take    = valid_i && !stall_o;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  always_comb begin
    ph_c = ph_q; ls_c = ls_q; hs_c = hs_q; mch_c = mch_q; mlen_c = mlen_q;
    mval_c = mval_q; ulen_c = ulen_q; maj_c = maj_q; min_c = min_q; mdig_c = mdig_q;
    hb_c = hb_q; nne_c = nne_q; mpos_c = mpos_q; mok_c = mok_q; lseen_c = lseen_q;
    lval_c = lval_q; lvld_c = lvld_q; bcnt_c = bcnt_q;
    if (data_i.clr) begin
      ph_c = PH_LINE; ls_c = L_MSTART; hs_c = H_START;
      for (int i = 0; i < METHOD_MAX_LEN; i++) mch_c[i] = '0;
      mlen_c = '0; mval_c = '0; ulen_c = '0; maj_c = 1'b0; min_c = '0; mdig_c = '0;
      hb_c = '0; nne_c = 1'b0; mpos_c = '0; mok_c = 1'b1; lseen_c = 1'b0;
      lval_c = '0; lvld_c = 1'b1; bcnt_c = '0;
    end
    ph_d = ph_c; ls_d = ls_c; hs_d = hs_c; mch_d = mch_c; mlen_d = mlen_c;
    mval_d = mval_c; ulen_d = ulen_c; maj_d = maj_c; min_d = min_c; mdig_d = mdig_c;
    hb_d = hb_c; nne_d = nne_c; mpos_d = mpos_c; mok_d = mok_c; lseen_d = lseen_c;
    lval_d = lval_c; lvld_d = lvld_c; bcnt_d = bcnt_c;
    st = hrbp_pkg::ST_PROGRESS; cls = hrbp_pkg::CL_NONE; ob = data_i.b; hle = 1'b0;
    mcode = lookup(mch_c, mlen_c);
    is_cl = mok_c && mpos_c == 5'd14;
    lv10 = {4'd0, lval_c} * 29'd10;
    nv = {21'd0, data_i.b[3:0]};
    bsize = (mval_c == 4'd3 && lseen_c && lvld_c) ? lval_c : '0;
    case (ph_c)
      PH_LINE: begin
        case (ls_c)
          L_MSTART, L_METHOD: begin
            if (ls_c == L_METHOD && data_i.sp) begin
              if (mcode == 4'd0) st = hrbp_pkg::ST_BAD_METH;
              else begin
                mval_d = mcode; ls_d = L_URI;
              end
            end else if (!data_i.alpha || int'(mlen_c) >= METHOD_MAX_LEN) begin
              st = hrbp_pkg::ST_BAD_METH;
            end else begin
              mch_d[mlen_c[MI-1:0]] = data_i.b; mlen_d = mlen_c + 1'b1;
              ls_d = L_METHOD; cls = hrbp_pkg::CL_METH;
            end
          end
          L_URI: begin
            if (data_i.sp) ls_d = L_H;
            else if (data_i.ctl) st = hrbp_pkg::ST_BAD_URI;
            else if (ulen_c >= uri_limit_i) st = hrbp_pkg::ST_URI_LONG;
            else begin
              ulen_d = ulen_c + 16'd1; cls = hrbp_pkg::CL_URI;
            end
          end
          L_H:  if (data_i.lo != "h") st = hrbp_pkg::ST_BAD_VER; else ls_d = L_T1;
          L_T1: if (data_i.lo != "t") st = hrbp_pkg::ST_BAD_VER; else ls_d = L_T2;
          L_T2: if (data_i.lo != "t") st = hrbp_pkg::ST_BAD_VER; else ls_d = L_P;
          L_P:  if (data_i.lo != "p") st = hrbp_pkg::ST_BAD_VER; else ls_d = L_SLASH;
          L_SLASH: if (data_i.b != "/") st = hrbp_pkg::ST_BAD_VER; else ls_d = L_MAJ;
          L_MAJ: begin
            if (data_i.b != "0" && data_i.b != "1") st = hrbp_pkg::ST_BAD_VER;
            else begin
              maj_d = data_i.b[0]; ls_d = L_DOT;
            end
          end
          L_DOT: if (data_i.b != ".") st = hrbp_pkg::ST_BAD_VER; else ls_d = L_MINSTART;
          L_MINSTART: begin
            if (!data_i.digit) st = hrbp_pkg::ST_BAD_VER;
            else begin
              mdig_d = 3'd1; min_d = {10'd0, data_i.b[3:0]}; ls_d = L_MINOR;
            end
          end
          L_MINOR: begin
            if (data_i.cr) ls_d = L_NL1;
            else if (!data_i.digit || int'(mdig_c) + 1 > MINOR_MAX_DIGITS)
              st = hrbp_pkg::ST_BAD_VER;
            else begin
              min_d = 14'(min_c * 14'd10 + {10'd0, data_i.b[3:0]});
              mdig_d = mdig_c + 3'd1;
            end
          end
          default: begin
            if (!data_i.lf) st = hrbp_pkg::ST_NL1_ERR; else ph_d = PH_HEAD;
          end
        endcase
      end
      PH_HEAD: begin
        if (hb_c + 17'd1 > {1'b0, hdr_limit_i}) st = hrbp_pkg::ST_HDR_BIG;
        else begin
          case (hs_c)
            H_START: begin
              if (data_i.cr) hs_d = H_NL3;
              else if (!data_i.token) st = hrbp_pkg::ST_KEY_ERR;
              else begin
                ob = data_i.lo; cls = hrbp_pkg::CL_NAME; nne_d = 1'b1; mpos_d = 5'd1;
                mok_d = data_i.lo == hrbp_pkg::cl_char(4'd0); hs_d = H_NAME;
              end
            end
            H_NAME: begin
              if (data_i.b == ":") hs_d = H_LWS;
              else if (!data_i.token) st = hrbp_pkg::ST_KEY_ERR;
              else begin
                if (mpos_c >= 5'd14 || data_i.lo != hrbp_pkg::cl_char(mpos_c[3:0]))
                  mok_d = 1'b0;
                if (mpos_c < 5'd31) mpos_d = mpos_c + 5'd1;
                cls = hrbp_pkg::CL_NAME;
              end
            end
            H_LWS, H_VALUE: begin
              if (data_i.cr) hs_d = H_NL2;
              else if (hs_c == H_LWS && (data_i.sp || data_i.tab)) hs_d = hs_c;
              else if (data_i.ctl) st = hrbp_pkg::ST_VAL_ERR;
              else begin
                hs_d = H_VALUE; cls = hrbp_pkg::CL_VALUE;
                if (is_cl && !lseen_c && lvld_c && !data_i.sp) begin
                  if (!data_i.digit || lval_c > BMAX10) lvld_d = 1'b0;
                  else if (lv10[24:0] > BMAX - nv) lvld_d = 1'b0;
                  else lval_d = lv10[24:0] + nv;
                end
              end
            end
            H_NL2: begin
              if (!data_i.lf) st = hrbp_pkg::ST_VAL_ERR;
              else begin
                if (is_cl) lseen_d = 1'b1;
                hle = nne_c; nne_d = 1'b0; mpos_d = '0; mok_d = 1'b1; hs_d = H_START;
              end
            end
            default: begin
              if (!data_i.lf) st = hrbp_pkg::ST_NL2_ERR;
              else if (bsize == '0) begin
                ph_d = PH_DONE; st = hrbp_pkg::ST_OK;
              end else begin
                ph_d = PH_BODY; bcnt_d = '0;
              end
            end
          endcase
          if (st == hrbp_pkg::ST_PROGRESS || st == hrbp_pkg::ST_OK) hb_d = hb_c + 17'd1;
        end
      end
      PH_BODY: begin
        bcnt_d = bcnt_c + 25'd1; cls = hrbp_pkg::CL_BODY;
        if (bcnt_d >= bsize) begin
          ph_d = PH_DONE; st = hrbp_pkg::ST_OK;
        end
      end
      default: st = hrbp_pkg::ST_DONE;
    endcase
    if (st >= hrbp_pkg::ST_BAD_METH) begin
      cls = hrbp_pkg::CL_NONE; ob = '0; hle = 1'b0;
      ph_d = ph_c; ls_d = ls_c; hs_d = hs_c; mch_d = mch_c; mlen_d = mlen_c;
      mval_d = mval_c; ulen_d = ulen_c; maj_d = maj_c; min_d = min_c; mdig_d = mdig_c;
      hb_d = hb_c; nne_d = nne_c; mpos_d = mpos_c; mok_d = mok_c; lseen_d = lseen_c;
      lval_d = lval_c; lvld_d = lvld_c; bcnt_d = bcnt_c;
    end
    blen = (ph_d == PH_BODY || ph_d == PH_DONE) ?
           ((mval_d == 4'd3 && lseen_d && lvld_d) ? lval_d : '0) : '0;
    out_d.status = st;
    out_d.byte_class = cls;
    out_d.out_byte = ob;
    out_d.header_line_end = hle;
    out_d.method_code = mval_d;
    out_d.version_major = maj_d;
    out_d.version_minor = min_d;
    out_d.body_length = blen[22:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      ph_q <= PH_LINE; ls_q <= L_MSTART; hs_q <= H_START;
      for (int i = 0; i < METHOD_MAX_LEN; i++) mch_q[i] <= '0;
      mlen_q <= '0; mval_q <= '0; ulen_q <= '0; maj_q <= 1'b0; min_q <= '0;
      mdig_q <= '0; hb_q <= '0; nne_q <= 1'b0; mpos_q <= '0; mok_q <= 1'b1;
      lseen_q <= 1'b0; lval_q <= '0; lvld_q <= 1'b1; bcnt_q <= '0;
    end else begin
      if (!stall_o) out_v_q <= valid_i;
      if (take) begin
        ph_q <= ph_d; ls_q <= ls_d; hs_q <= hs_d; mch_q <= mch_d; mlen_q <= mlen_d;
        mval_q <= mval_d; ulen_q <= ulen_d; maj_q <= maj_d; min_q <= min_d;
        mdig_q <= mdig_d; hb_q <= hb_d; nne_q <= nne_d; mpos_q <= mpos_d;
        mok_q <= mok_d; lseen_q <= lseen_d; lval_q <= lval_d; lvld_q <= lvld_d;
        bcnt_q <= bcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end
endmodule

// File: rtl/http_request_byte_parser_unit.sv
`timescale 1ns / 1ps
// HTTP/1.1 request byte parser.
// Input channel: one request byte per word (in_valid_i / in_stall_o), with a
// new_request flag that clears the parser before that byte is handled.
// Output channel: one result word per input word (out_valid_o / out_stall_i):
// status, byte class, streamed byte and decoded method, version and body size.
// Config: cfg_we_i writes header_byte_limit (index 0) or uri_byte_limit
// (index 1) from cfg_data_i; write only while idle.
// Throughput: one byte per cycle unless out_stall_i holds the flow; the whole
// per-byte state update is combinational in the back end.
// Path: the result word passes the classify register, the 2-entry queue and
// the output register, in that order.
// Reset clears all parser state and restores the limits to 8192 and 2048.
// A stalled receiver holds the result; the queue absorbs in-flight words and
// then in_stall_o rises, so no word is lost.
module http_request_byte_parser_unit #(
  parameter int METHOD_MAX_LEN   = 8,
  parameter int BODY_MAX         = 4194304,
  parameter int MINOR_MAX_DIGITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrbp_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrbp_pkg::out_word_t out_data_o
);
  logic [15:0] hdr_lim_q, uri_lim_q;
  logic        f_v, f_s, q_v, q_s;
  hrbp_pkg::cls_word_t f_d, q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_lim_q <= 16'd8192;
      uri_lim_q <= 16'd2048;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hrbp_pkg::REG_HDR_LIMIT: hdr_lim_q <= cfg_data_i;
        hrbp_pkg::REG_URI_LIMIT: uri_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hrbp_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .stall_o(in_stall_o), .data_i(in_data_i),
    .valid_o(f_v), .stall_i(f_s), .data_o(f_d)
  );

  hrbp_queue u_queue (
    .clk_i, .rst_ni, .valid_i(f_v), .stall_o(f_s), .data_i(f_d),
    .valid_o(q_v), .stall_i(q_s), .data_o(q_d)
  );

  hrbp_back #(
    .METHOD_MAX_LEN(METHOD_MAX_LEN), .BODY_MAX(BODY_MAX),
    .MINOR_MAX_DIGITS(MINOR_MAX_DIGITS)
  ) u_back (
    .clk_i, .rst_ni, .hdr_limit_i(hdr_lim_q), .uri_limit_i(uri_lim_q),
    .valid_i(q_v), .stall_o(q_s), .data_i(q_d),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );
endmodule

// File: sim/tb_http_request_byte_parser_unit.sv
`timescale 1ns / 1ps
module tb_http_request_byte_parser_unit;

  typedef enum int {PH_LINE, PH_HEAD, PH_BODY, PH_DONE} phase_e;
  typedef enum int {L_MSTART, L_METHOD, L_URI, L_H, L_T1, L_T2, L_P, L_SLASH, L_MAJ,
                    L_DOT, L_MINSTART, L_MINOR, L_NL1} line_e;
  typedef enum int {H_START, H_LWS, H_NAME, H_VALUE, H_NL2, H_NL3} hdr_e;

  localparam int MAX_METH  = 8;
  localparam int MAX_BODY  = 4194304;
  localparam int MAX_MINOR = 4;
  localparam string CL_TEXT = "content-length";

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [15:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  hrbp_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hrbp_pkg::out_word_t out_data_o;

  http_request_byte_parser_unit uut (.*);

  always #5 clk_i = ~clk_i;

  string meth_names[9] = '{"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT", "OPTIONS",
                           "TRACE", "PATCH"};

  // parser shadow state
  phase_e ph;
  line_e  ls;
  hdr_e   hs;
  logic [7:0] mchars[MAX_METH];
  int mlen, mcode, ulen, vmaj, vmin, vdig, hbytes, cl_pos, cl_val, body_cnt;
  bit name_seen, cl_ok, cl_seen, cl_good;
  int hdr_lim = 8192;
  int uri_lim = 2048;

  hrbp_pkg::in_word_t  word_q[$];
  hrbp_pkg::out_word_t result_q[$];
  logic [7:0] req_q[$];
  int errors = 0;

  function automatic void clear_parser();
    ph = PH_LINE; ls = L_MSTART; hs = H_START;
    foreach (mchars[i]) mchars[i] = 8'h00;
    mlen = 0; mcode = 0; ulen = 0; vmaj = 0; vmin = 0; vdig = 0; hbytes = 0;
    name_seen = 0; cl_pos = 0; cl_ok = 1; cl_seen = 0; cl_val = 0; cl_good = 1;
    body_cnt = 0;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_ctl(logic [7:0] c);
    return c <= 31 || c == 127;
  endfunction
  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
  function automatic bit is_token(logic [7:0] c);
    bit sp;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}", " ", 8'h09: sp = 1;
      default: sp = 0;
    endcase
    return c <= 127 && !is_ctl(c) && !sp;
  endfunction

  function automatic int find_method();
    bit ok;
    for (int k = 0; k < 9; k++) begin
      if (meth_names[k].len() != mlen) continue;
      ok = 1;
      for (int i = 0; i < mlen; i++) if (mchars[i] != meth_names[k][i]) ok = 0;
      if (ok) return k + 1;
    end
    return 0;
  endfunction

  function automatic bit is_cl();
    return cl_ok && cl_pos == 14;
  endfunction

  function automatic int body_size();
    return (mcode == 3 && cl_seen && cl_good) ? cl_val : 0;
  endfunction

  function automatic logic [3:0] line_step(logic [7:0] b, inout logic [2:0] cls);
    int m;
    case (ls)
      L_MSTART, L_METHOD: begin
        if (ls == L_METHOD && b == " ") begin
          m = find_method();
          if (m == 0) return hrbp_pkg::ST_BAD_METH;
          mcode = m; ls = L_URI; return hrbp_pkg::ST_PROGRESS;
        end
        if (!is_alpha(b) || mlen >= MAX_METH) return hrbp_pkg::ST_BAD_METH;
        mchars[mlen] = b; mlen++; ls = L_METHOD; cls = hrbp_pkg::CL_METH;
        return hrbp_pkg::ST_PROGRESS;
      end
      L_URI: begin
        if (b == " ") begin ls = L_H; return hrbp_pkg::ST_PROGRESS; end
        if (is_ctl(b)) return hrbp_pkg::ST_BAD_URI;
        if (ulen >= uri_lim) return hrbp_pkg::ST_URI_LONG;
        ulen++; cls = hrbp_pkg::CL_URI; return hrbp_pkg::ST_PROGRESS;
      end
      L_H: begin
        if (lc(b) != "h") return hrbp_pkg::ST_BAD_VER;
        ls = L_T1; return hrbp_pkg::ST_PROGRESS;
      end
      L_T1: begin
        if (lc(b) != "t") return hrbp_pkg::ST_BAD_VER;
        ls = L_T2; return hrbp_pkg::ST_PROGRESS;
      end
      L_T2: begin
        if (lc(b) != "t") return hrbp_pkg::ST_BAD_VER;
        ls = L_P; return hrbp_pkg::ST_PROGRESS;
      end
      L_P: begin
        if (lc(b) != "p") return hrbp_pkg::ST_BAD_VER;
        ls = L_SLASH; return hrbp_pkg::ST_PROGRESS;
      end
      L_SLASH: begin
        if (b != "/") return hrbp_pkg::ST_BAD_VER;
        ls = L_MAJ; return hrbp_pkg::ST_PROGRESS;
      end
      L_MAJ: begin
        if (b != "0" && b != "1") return hrbp_pkg::ST_BAD_VER;
        vmaj = b - "0"; ls = L_DOT; return hrbp_pkg::ST_PROGRESS;
      end
      L_DOT: begin
        if (b != ".") return hrbp_pkg::ST_BAD_VER;
        ls = L_MINSTART; return hrbp_pkg::ST_PROGRESS;
      end
      L_MINSTART: begin
        if (!is_digit(b)) return hrbp_pkg::ST_BAD_VER;
        vdig = 1; vmin = b - "0"; ls = L_MINOR; return hrbp_pkg::ST_PROGRESS;
      end
      L_MINOR: begin
        if (b == 8'h0d) begin ls = L_NL1; return hrbp_pkg::ST_PROGRESS; end
        if (!is_digit(b) || vdig + 1 > MAX_MINOR) return hrbp_pkg::ST_BAD_VER;
        vmin = vmin * 10 + (b - "0"); vdig++; return hrbp_pkg::ST_PROGRESS;
      end
      default: begin
        if (b != 8'h0a) return hrbp_pkg::ST_NL1_ERR;
        ph = PH_HEAD; return hrbp_pkg::ST_PROGRESS;
      end
    endcase
  endfunction

  function automatic logic [3:0] header_step(logic [7:0] b, inout logic [2:0] cls,
                                             inout logic [7:0] ob, inout logic hle);
    int nv;
    if (hbytes + 1 > hdr_lim) return hrbp_pkg::ST_HDR_BIG;
    case (hs)
      H_START: begin
        if (b == 8'h0d) hs = H_NL3;
        else begin
          if (!is_token(b)) return hrbp_pkg::ST_KEY_ERR;
          ob = lc(b); cls = hrbp_pkg::CL_NAME;
          name_seen = 1; cl_pos = 1; cl_ok = (ob == CL_TEXT[0]);
          hs = H_NAME;
        end
      end
      H_NAME: begin
        if (b == ":") hs = H_LWS;
        else begin
          if (!is_token(b)) return hrbp_pkg::ST_KEY_ERR;
          if (cl_pos >= 14 || lc(b) != CL_TEXT[cl_pos]) cl_ok = 0;
          if (cl_pos < 31) cl_pos++;
          cls = hrbp_pkg::CL_NAME;
        end
      end
      H_LWS, H_VALUE: begin
        if (b == 8'h0d) hs = H_NL2;
        else if (!(hs == H_LWS && (b == " " || b == 8'h09))) begin
          if (is_ctl(b)) return hrbp_pkg::ST_VAL_ERR;
          if (is_cl() && !cl_seen && cl_good && b != " ") begin
            if (!is_digit(b) || cl_val > MAX_BODY / 10) cl_good = 0;
            else begin
              nv = b - "0";
              cl_val = cl_val * 10;
              if (cl_val > MAX_BODY - nv) cl_good = 0;
              else cl_val = cl_val + nv;
            end
          end
          hs = H_VALUE; cls = hrbp_pkg::CL_VALUE;
        end
      end
      H_NL2: begin
        if (b != 8'h0a) return hrbp_pkg::ST_VAL_ERR;
        if (is_cl()) cl_seen = 1;
        hle = name_seen;
        name_seen = 0; cl_pos = 0; cl_ok = 1; hs = H_START;
      end
      default: begin
        if (b != 8'h0a) return hrbp_pkg::ST_NL2_ERR;
        hbytes++;
        if (body_size() == 0) begin ph = PH_DONE; return hrbp_pkg::ST_OK; end
        ph = PH_BODY; body_cnt = 0; return hrbp_pkg::ST_PROGRESS;
      end
    endcase
    hbytes++;
    return hrbp_pkg::ST_PROGRESS;
  endfunction

  function automatic hrbp_pkg::out_word_t predict_parse(hrbp_pkg::in_word_t w);
    hrbp_pkg::out_word_t r;
    logic [7:0] ob;
    logic [3:0] st;
    logic [2:0] cls;
    logic       hle;
    ob = w.in_byte; st = hrbp_pkg::ST_PROGRESS; cls = hrbp_pkg::CL_NONE; hle = 1'b0;
    if (w.new_request) clear_parser();
    case (ph)
      PH_LINE: st = line_step(w.in_byte, cls);
      PH_HEAD: st = header_step(w.in_byte, cls, ob, hle);
      PH_BODY: begin
        body_cnt++; cls = hrbp_pkg::CL_BODY;
        if (body_cnt >= body_size()) begin ph = PH_DONE; st = hrbp_pkg::ST_OK; end
      end
      default: st = hrbp_pkg::ST_DONE;
    endcase
    if (st >= hrbp_pkg::ST_BAD_METH) begin
      cls = hrbp_pkg::CL_NONE; ob = 8'h00; hle = 1'b0;
    end
    r.status = st;
    r.byte_class = cls;
    r.out_byte = ob;
    r.header_line_end = hle;
    r.method_code = mcode[3:0];
    r.version_major = vmaj[0];
    r.version_minor = vmin[13:0];
    r.body_length = 23'((ph == PH_BODY || ph == PH_DONE) ? body_size() : 0);
    return r;
  endfunction

  // driver: bursts of words with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        result_q.insert(result_q.size(), predict_parse(in_data_i));
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= word_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor with its own stall pattern
  int stall_lvl = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    hrbp_pkg::out_word_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_lvl <= $urandom_range(0, 6);
      out_stall_i <= ($urandom_range(0, 7) < stall_lvl);
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          e = result_q.pop_front();
          check_field("status", e.status, out_data_o.status);
          check_field("byte_class", e.byte_class, out_data_o.byte_class);
          check_field("out_byte", e.out_byte, out_data_o.out_byte);
          check_field("header_line_end", e.header_line_end, out_data_o.header_line_end);
          check_field("method_code", e.method_code, out_data_o.method_code);
          check_field("version_major", e.version_major, out_data_o.version_major);
          check_field("version_minor", e.version_minor, out_data_o.version_minor);
          check_field("body_length", e.body_length, out_data_o.body_length);
        end
      end
    end
  end

  task automatic add_byte(logic [7:0] c);
    req_q.insert(req_q.size(), c);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic flush_req();
    hrbp_pkg::in_word_t w;
    for (int i = 0; i < req_q.size(); i++) begin
      w.in_byte = req_q[i];
      w.new_request = (i == 0);
      word_q.insert(word_q.size(), w);
    end
    req_q.delete();
  endtask

  task automatic rand_case(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      add_byte(c);
    end
  endtask

  task automatic gen_request();
    int k, n, blen;
    bit post;
    k = $urandom_range(0, 8);
    post = 0;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) add_byte(8'($urandom_range(0, 1) ? $urandom_range("A", "Z")
                                                  : $urandom_range("a", "z")));
    end else begin
      if ($urandom_range(0, 2) == 0) k = 2;
      add_str(meth_names[k]);
      post = (k == 2);
    end
    add_byte(" ");
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
    repeat (n) add_byte(8'($urandom_range(8'h21, 8'hfe)));
    add_byte(" ");
    rand_case("http/");
    add_byte(8'($urandom_range("0", "1")));
    add_byte(".");
    n = $urandom_range(1, 5);
    repeat (n) add_byte(8'($urandom_range("0", "9")));
    add_str("\r\n");
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        rand_case(CL_TEXT);
        add_str(":");
        if ($urandom_range(0, 1)) add_str(" ");
        case ($urandom_range(0, 7))
          0: add_str("4194304");
          1: add_str("4194305");
          2: add_str("12a");
          3: add_str("99999999");
          4: ;
          default: begin
            blen = $urandom_range(0, 12);
            add_str($sformatf("%0d", blen));
            if ($urandom_range(0, 3) == 0) add_str(" ");
          end
        endcase
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) add_byte(8'($urandom_range("a", "z")));
        add_str(":");
        k = $urandom_range(0, 6);
        repeat (k) add_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      add_str("\r\n");
    end
    add_str("\r\n");
    if (post) begin
      n = $urandom_range(0, 14);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
    n = $urandom_range(0, 2);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
    // occasionally corrupt one byte
    if ($urandom_range(0, 5) == 0)
      req_q[$urandom_range(0, req_q.size() - 1)] = 8'($urandom_range(0, 255));
    flush_req();
  endtask

  task automatic gen_phase(int count);
    hrbp_pkg::in_word_t w;
    int target;
    target = word_q.size() + count;
    while (word_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        w.in_byte = 8'($urandom_range(0, 255));
        w.new_request = 1'($urandom_range(0, 1));
        word_q.insert(word_q.size(), w);
      end else begin
        gen_request();
      end
    end
  endtask

  task automatic wait_drained();
    while (word_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limits(int hdr, int uri);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= hrbp_pkg::REG_HDR_LIMIT;
    cfg_data_i <= hdr[15:0];
    @(posedge clk_i);
    cfg_index_i <= hrbp_pkg::REG_URI_LIMIT;
    cfg_data_i <= uri[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_lim = hdr;
    uri_lim = uri;
    @(posedge clk_i);
  endtask

  initial begin
    clear_parser();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    add_str("GET / HTTP/1.0\r\n\r\nx");
    flush_req();
    add_str("ABCDEFGHI");
    flush_req();
    add_str("POST /a HTTP/1.12\r\nContent-Length: 2\r\n\r\n");
    add_byte(8'hff);
    add_byte(8'h00);
    flush_req();
    gen_phase(300);
    set_limits(65535, 65535);
    gen_phase(300);
    set_limits(0, 0);
    gen_phase(150);
    set_limits(1, 1);
    gen_phase(150);
    set_limits(30, 4);
    gen_phase(400);
    set_limits($urandom_range(20, 200), $urandom_range(1, 10));
    gen_phase(400);
    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
